// ----- rtl/rbt_pkg.sv -----
// ----------------------------------------------------------------------------
// rbt_pkg
// Shared types and constants for the record byte transposer.
// ----------------------------------------------------------------------------
package rbt_pkg;

  localparam int RBT_MAX_RECORD_BYTES = 64;
  localparam int RBT_MAX_RECORDS      = 64;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int BYTE_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION    = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic DIR_FORWARD = 1'b0;

  typedef enum logic {
    ST_IDLE,
    ST_FETCH
  } rbt_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic wr_req;    // write request accepted
    logic rd_req;    // read request accepted
    logic out_load;  // capture store data into output register
    logic cfg_we;    // configuration write
  } rbt_cmd_t;

endpackage

// ----- rtl/rbt_ram.sv -----
// ----------------------------------------------------------------------------
// rbt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/rbt_datapath.sv -----
// ----------------------------------------------------------------------------
// rbt_datapath
// Geometry registers, load pointer, permuted read address counters, byte
// store and output register.
// ----------------------------------------------------------------------------
module rbt_datapath
  import rbt_pkg::*;
#(
  parameter int MAX_RECORD_BYTES = RBT_MAX_RECORD_BYTES,
  parameter int MAX_RECORDS      = RBT_MAX_RECORDS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rbt_cmd_t              cmd,
  input  logic [BYTE_W-1:0]     in_data_byte,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [BYTE_W-1:0]     out_byte,
  output logic                  out_last,
  output logic                  out_error
);

  localparam int DEPTH  = MAX_RECORD_BYTES * MAX_RECORDS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW     = $clog2(DEPTH + 1);
  localparam int SW     = $clog2(MAX_RECORD_BYTES + 1);
  localparam int CW     = $clog2(MAX_RECORDS + 1);
  localparam int MAXDIM = (MAX_RECORD_BYTES > MAX_RECORDS) ? MAX_RECORD_BYTES : MAX_RECORDS;
  localparam int KW     = $clog2(MAXDIM + 1);

  logic [SW-1:0] size_r, size_nxt, size_new;
  logic [CW-1:0] count_r, count_nxt, count_new;
  logic          dir_r, dir_nxt;
  logic [LW-1:0] total_r, total_nxt;
  logic [LW-1:0] load_ptr_r, load_ptr_nxt;
  logic [KW-1:0] inner_r, inner_nxt;
  logic [KW-1:0] outer_r, outer_nxt;
  logic [AW-1:0] read_base_r, read_base_nxt;

  logic [SW-1:0]    mul_a;
  logic [CW-1:0]    mul_b;
  logic [SW+CW-1:0] product;
  logic             cfg_known;

  logic          loaded;
  logic          mem_we;
  logic [BYTE_W-1:0] mem_rdata;
  logic [KW-1:0] inner_lim, outer_lim, inner_inc, outer_inc;
  logic [AW-1:0] stride;
  logic          wrap, final_byte;

  logic              pend_last_r, pend_err_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r, out_error_r;

  // clamp incoming geometry: 0 acts as 1, large values saturate
  always_comb begin
    if (cfg_data == '0) begin
      size_new  = SW'(1);
      count_new = CW'(1);
    end else begin
      size_new  = (32'(cfg_data) > MAX_RECORD_BYTES) ? SW'(MAX_RECORD_BYTES) : SW'(cfg_data);
      count_new = (32'(cfg_data) > MAX_RECORDS) ? CW'(MAX_RECORDS) : CW'(cfg_data);
    end
  end

  always_comb begin
    cfg_known = (cfg_index == CFG_RECORD_SIZE) || (cfg_index == CFG_RECORD_COUNT) ||
                (cfg_index == CFG_DIRECTION);
    mul_a     = (cfg_index == CFG_RECORD_SIZE) ? size_new : size_r;
    mul_b     = (cfg_index == CFG_RECORD_COUNT) ? count_new : count_r;
    product   = (SW + CW)'(mul_a) * (SW + CW)'(mul_b);
  end

  always_comb begin
    loaded     = (load_ptr_r >= total_r);
    mem_we     = cmd.wr_req && !loaded;
    inner_lim  = (dir_r == DIR_FORWARD) ? KW'(count_r) : KW'(size_r);
    outer_lim  = (dir_r == DIR_FORWARD) ? KW'(size_r) : KW'(count_r);
    stride     = (dir_r == DIR_FORWARD) ? AW'(size_r) : AW'(count_r);
    inner_inc  = inner_r + KW'(1);
    outer_inc  = outer_r + KW'(1);
    wrap       = (inner_inc >= inner_lim);
    final_byte = wrap && (outer_inc >= outer_lim);
  end

  always_comb begin
    size_nxt      = size_r;
    count_nxt     = count_r;
    dir_nxt       = dir_r;
    total_nxt     = total_r;
    load_ptr_nxt  = load_ptr_r;
    inner_nxt     = inner_r;
    outer_nxt     = outer_r;
    read_base_nxt = read_base_r;
    if (cmd.cfg_we) begin
      if (cfg_known) begin
        case (cfg_index)
          CFG_RECORD_SIZE:  size_nxt  = size_new;
          CFG_RECORD_COUNT: count_nxt = count_new;
          CFG_DIRECTION:    dir_nxt   = cfg_data[0];
          default:          dir_nxt   = dir_r;
        endcase
        total_nxt     = LW'(product);
        load_ptr_nxt  = '0;
        inner_nxt     = '0;
        outer_nxt     = '0;
        read_base_nxt = '0;
      end
    end else if (mem_we) begin
      load_ptr_nxt = load_ptr_r + LW'(1);
    end else if (cmd.rd_req && loaded) begin
      if (final_byte) begin
        load_ptr_nxt  = '0;
        inner_nxt     = '0;
        outer_nxt     = '0;
        read_base_nxt = '0;
      end else if (wrap) begin
        inner_nxt     = '0;
        outer_nxt     = outer_inc;
        read_base_nxt = AW'(outer_inc);
      end else begin
        inner_nxt     = inner_inc;
        read_base_nxt = read_base_r + stride;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= SW'(1);
      count_r     <= CW'(1);
      dir_r       <= DIR_FORWARD;
      total_r     <= LW'(1);
      load_ptr_r  <= '0;
      inner_r     <= '0;
      outer_r     <= '0;
      read_base_r <= '0;
    end else begin
      size_r      <= size_nxt;
      count_r     <= count_nxt;
      dir_r       <= dir_nxt;
      total_r     <= total_nxt;
      load_ptr_r  <= load_ptr_nxt;
      inner_r     <= inner_nxt;
      outer_r     <= outer_nxt;
      read_base_r <= read_base_nxt;
    end
  end

  rbt_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (load_ptr_r[AW-1:0]),
    .wdata (in_data_byte),
    .re    (cmd.rd_req),
    .raddr (read_base_r),
    .rdata (mem_rdata)
  );

  // flags of the request in flight, joined with store data in the following cycle
  always_ff @(posedge clk) begin
    if (cmd.rd_req) begin
      pend_err_r  <= !loaded;
      pend_last_r <= loaded && final_byte;
    end
    if (cmd.out_load) begin
      out_byte_r  <= pend_err_r ? '0 : mem_rdata;
      out_last_r  <= pend_last_r;
      out_error_r <= pend_err_r;
    end
  end

  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign out_error = out_error_r;

endmodule

// ----- rtl/rbt_ctrl.sv -----
// ----------------------------------------------------------------------------
// rbt_ctrl
// Handshake control: accepts requests, sequences the store read and owns
// the output valid flag.
// ----------------------------------------------------------------------------
module rbt_ctrl
  import rbt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_op,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  output rbt_cmd_t cmd
);

  rbt_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_accept;

  assign in_accept = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_accept && in_op == OP_READ) state_nxt = ST_FETCH;
      ST_FETCH: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    cfg_ready    = 1'b0;
    cmd.out_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // output register must be free or draining this cycle;
        // an offered config write goes first
        in_stall  = (out_valid_r && out_stall) || cfg_valid;
        cfg_ready = 1'b1;
      end
      ST_FETCH: begin
        cmd.out_load = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
    cmd.wr_req = in_accept && (in_op == OP_WRITE);
    cmd.rd_req = in_accept && (in_op == OP_READ);
    cmd.cfg_we = cfg_valid && cfg_ready;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/record_byte_transposer.sv -----
// ----------------------------------------------------------------------------
// record_byte_transposer
// Byte-shuffle engine: loads a batch of fixed-size records, then returns
// the bytes grouped by byte lane (forward) or regrouped by record (reverse).
//
//   channel  handshake             payload
//   in_      in_valid / in_stall   in_op, in_data_byte
//   out_     out_valid / out_stall out_byte, out_last, out_error
//   cfg_     cfg_valid / cfg_ready cfg_index, cfg_data
//
// For a read request, the byte store's registered read port fetches the byte
// and the fetch state then loads it into the output register; no request is
// taken in that state. A request is held off while a result sits stalled in
// the output register or a config write is offered. Synchronous reset rst_n
// clears control state; store contents are undefined until loaded.
// ----------------------------------------------------------------------------
module record_byte_transposer
  import rbt_pkg::*;
#(
  parameter int MAX_RECORD_BYTES = RBT_MAX_RECORD_BYTES,
  parameter int MAX_RECORDS      = RBT_MAX_RECORDS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_op,
  input  logic [BYTE_W-1:0]     in_data_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BYTE_W-1:0]     out_byte,
  output logic                  out_last,
  output logic                  out_error,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  rbt_cmd_t cmd;

  rbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  rbt_datapath #(
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES),
    .MAX_RECORDS      (MAX_RECORDS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_data_byte (in_data_byte),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .out_error    (out_error)
  );

endmodule

// ----- sim/record_byte_transposer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// record_byte_transposer_tb
// Self-checking bench for the byte transposer. A short table of requests
// covers reset values, size clamping, overflow writes, early reads, config
// aborts and the unknown register. Random batches follow, mostly complete
// load-then-drain sequences with a little noise. Every result is compared
// with a typed table row or a shadow of the batch buffer and read counters.
// ----------------------------------------------------------------------------
module record_byte_transposer_tb;
  import rbt_pkg::*;

  localparam int          STORE_DEPTH    = RBT_MAX_RECORD_BYTES * RBT_MAX_RECORDS;
  localparam int          RANDOM_ITEMS   = 1000;
  localparam int          SETTLE_CYCLES  = 4;
  localparam int          HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int          N_EXTREMES     = 4;

  // register index past the end of the list
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              err;
  } shuffle_rec_t;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic                op;
    logic [BYTE_W-1:0]   val;
    logic [CFG_IDX_W-1:0] idx;
    logic                typed;
    shuffle_rec_t        want;
  } plan_row_t;

  localparam shuffle_rec_t NONE    = '{8'h00, 1'b0, 1'b0};
  localparam shuffle_rec_t EARLY   = '{8'h00, 1'b0, 1'b1};

  // directed requests; typed expectations only where they are obvious
  plan_row_t plan [0:24] = '{
    '{ROW_REQ, OP_READ,  8'h00, CFG_RECORD_SIZE,  1'b1, EARLY},
    '{ROW_REQ, OP_WRITE, 8'hFF, CFG_RECORD_SIZE,  1'b0, NONE},
    '{ROW_REQ, OP_WRITE, 8'h00, CFG_RECORD_SIZE,  1'b0, NONE},   // dropped, full
    '{ROW_REQ, OP_READ,  8'hFF, CFG_RECORD_SIZE,  1'b1, '{8'hFF, 1'b1, 1'b0}},
    '{ROW_CFG, OP_WRITE, 8'h00, CFG_RECORD_SIZE,  1'b0, NONE},   // zero acts as one
    '{ROW_CFG, OP_WRITE, 8'h02, CFG_RECORD_COUNT, 1'b0, NONE},
    '{ROW_REQ, OP_WRITE, 8'h00, CFG_RECORD_SIZE,  1'b0, NONE},
    '{ROW_REQ, OP_READ,  8'h55, CFG_RECORD_SIZE,  1'b1, EARLY},
    '{ROW_REQ, OP_WRITE, 8'h80, CFG_RECORD_SIZE,  1'b0, NONE},
    '{ROW_REQ, OP_READ,  8'h00, CFG_RECORD_SIZE,  1'b1, '{8'h00, 1'b0, 1'b0}},
    '{ROW_REQ, OP_READ,  8'hAA, CFG_RECORD_SIZE,  1'b1, '{8'h80, 1'b1, 1'b0}},
    '{ROW_REQ, OP_READ,  8'h00, CFG_RECORD_SIZE,  1'b1, EARLY},  // new batch empty
    '{ROW_CFG, OP_WRITE, 8'h02, CFG_RECORD_SIZE,  1'b0, NONE},
    '{ROW_REQ, OP_WRITE, 8'h11, CFG_RECORD_SIZE,  1'b0, NONE},
    '{ROW_CFG, OP_WRITE, 8'h7F, CFG_NO_REG,       1'b0, NONE},   // no such register
    '{ROW_CFG, OP_WRITE, 8'h01, CFG_DIRECTION,    1'b0, NONE},   // aborts the batch
    '{ROW_REQ, OP_WRITE, 8'h01, CFG_RECORD_SIZE,  1'b0, NONE},
    '{ROW_REQ, OP_WRITE, 8'h02, CFG_RECORD_SIZE,  1'b0, NONE},
    '{ROW_REQ, OP_WRITE, 8'h04, CFG_RECORD_SIZE,  1'b0, NONE},
    '{ROW_REQ, OP_WRITE, 8'h08, CFG_RECORD_SIZE,  1'b0, NONE},
    '{ROW_REQ, OP_READ,  8'h00, CFG_RECORD_SIZE,  1'b0, NONE},
    '{ROW_REQ, OP_READ,  8'h00, CFG_RECORD_SIZE,  1'b0, NONE},
    '{ROW_REQ, OP_READ,  8'h00, CFG_RECORD_SIZE,  1'b0, NONE},
    '{ROW_REQ, OP_READ,  8'h00, CFG_RECORD_SIZE,  1'b0, NONE},
    '{ROW_REQ, OP_READ,  8'h00, CFG_RECORD_SIZE,  1'b1, EARLY}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_op;
  logic [BYTE_W-1:0]     in_data_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic [BYTE_W-1:0]     out_byte;
  logic                  out_last;
  logic                  out_error;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // shadow of the block
  logic [BYTE_W-1:0]     shadow_store [0:STORE_DEPTH-1];
  int unsigned           loaded_cnt = 0;
  int unsigned           outer_idx  = 0;
  int unsigned           inner_idx  = 0;
  int unsigned           read_addr  = 0;
  logic [CFG_DATA_W-1:0] reg_size   = 7'd1;
  logic [CFG_DATA_W-1:0] reg_count  = 7'd1;
  logic                  reg_dir    = DIR_FORWARD;

  shuffle_rec_t pending_bytes [$];
  int unsigned  mismatches   = 0;
  int unsigned  live_reqs    = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  tx_rate      = 1;
  bit           calm         = 1'b0;
  bit           hold_go      = 1'b0;
  bit           hold_done    = 1'b0;

  always #5 clk = ~clk;

  record_byte_transposer u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .out_error    (out_error),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  function automatic int unsigned clamp_dim(logic [CFG_DATA_W-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int unsigned batch_total();
    return clamp_dim(reg_size, RBT_MAX_RECORD_BYTES) * clamp_dim(reg_count, RBT_MAX_RECORDS);
  endfunction

  function automatic void clear_batch();
    loaded_cnt = 0;
    outer_idx  = 0;
    inner_idx  = 0;
    read_addr  = 0;
  endfunction

  function automatic void shadow_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_RECORD_SIZE: begin
        reg_size = val;
        clear_batch();
      end
      CFG_RECORD_COUNT: begin
        reg_count = val;
        clear_batch();
      end
      CFG_DIRECTION: begin
        reg_dir = val[0];
        clear_batch();
      end
      default: ;
    endcase
  endfunction

  // advances the shadow by one request; returns 1 when a result byte is due
  function automatic bit permute_step(logic op, logic [BYTE_W-1:0] d, output shuffle_rec_t r);
    int unsigned s_eff, c_eff, inner_lim, outer_lim, stride;
    bit          fin;
    s_eff = clamp_dim(reg_size, RBT_MAX_RECORD_BYTES);
    c_eff = clamp_dim(reg_count, RBT_MAX_RECORDS);
    r = NONE;
    if (op == OP_WRITE) begin
      if (loaded_cnt < s_eff * c_eff) begin
        shadow_store[loaded_cnt] = d;
        loaded_cnt++;
      end
      return 1'b0;
    end
    if (loaded_cnt < s_eff * c_eff) begin
      r = EARLY;
      return 1'b1;
    end
    if (reg_dir == DIR_FORWARD) begin
      inner_lim = c_eff;
      outer_lim = s_eff;
      stride    = s_eff;
    end else begin
      inner_lim = s_eff;
      outer_lim = c_eff;
      stride    = c_eff;
    end
    r.data = shadow_store[read_addr];
    fin = 1'b0;
    inner_idx++;
    if (inner_idx >= inner_lim) begin
      inner_idx = 0;
      outer_idx++;
      if (outer_idx >= outer_lim) fin = 1'b1;
      else read_addr = outer_idx;
    end else begin
      read_addr += stride;
    end
    r.last = fin;
    if (fin) clear_batch();
    return 1'b1;
  endfunction

  task automatic send_request(input logic op, input logic [BYTE_W-1:0] d,
                              input bit typed = 1'b0, input shuffle_rec_t fixed = NONE);
    shuffle_rec_t got;
    cfg_valid <= 1'b0;
    if ($urandom_range(0, 255) == 0) tx_rate = $urandom_range(0, 3);
    if (!calm && $urandom_range(1, 12) <= tx_rate) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_data_byte <= d;
    do @(posedge clk); while (in_stall);
    if (!(op == OP_WRITE && loaded_cnt >= batch_total())) live_reqs++;
    if (permute_step(op, d, got)) pending_bytes.push_back(typed ? fixed : got);
  endtask

  // a write leaves no result behind, so allow the pipe to settle after the drain
  task automatic wait_drained();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    shadow_cfg(idx, val);
  endtask

  task automatic run_batch();
    int unsigned total, mode, n_reads;
    total = batch_total();
    mode  = $urandom_range(0, 19);
    if (mode == 0) begin
      repeat ($urandom_range(1, 2 * total + 2))
        send_request(1'($urandom_range(0, 1)), 8'($urandom));
    end else begin
      for (int k = 0; k < total; k++) begin
        if ($urandom_range(0, 15) == 0) send_request(OP_READ, 8'($urandom));
        send_request(OP_WRITE, 8'($urandom));
      end
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) send_request(OP_WRITE, 8'($urandom));
      hold_go = 1'b1;
      // now and then stop partway so the next batch lands on a half-read buffer
      n_reads = (mode == 1) ? $urandom_range(0, total - 1) : total;
      repeat (n_reads) send_request(OP_READ, 8'($urandom));
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 23);
    if (r == 0) return 7'd0;
    if (r == 1) return 7'($urandom_range(65, 127));
    if (r < 4) return 7'($urandom_range(9, 20));
    return 7'($urandom_range(1, 8));
  endfunction

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] ext_size [0:N_EXTREMES-1];
    logic [CFG_DATA_W-1:0] ext_count [0:N_EXTREMES-1];
    logic                  ext_dir [0:N_EXTREMES-1];
    logic [CFG_DATA_W-1:0] vals [0:2];
    int unsigned           phase, ext_reqs, first;
    ext_size  = '{7'd127, 7'd1,   7'd64, 7'd0};
    ext_count = '{7'd2,   7'd100, 7'd1,  7'd0};
    ext_dir   = '{1'b0,   1'b1,   1'b0,  1'b1};
    phase     = 0;
    ext_reqs  = 0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_op        <= OP_WRITE;
    in_data_byte <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= CFG_RECORD_SIZE;
    cfg_data     <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < 25; r++) begin
      if (plan[r].kind == ROW_CFG) begin
        wait_drained();
        cfg_write(plan[r].idx, plan[r].val[CFG_DATA_W-1:0]);
      end else begin
        send_request(plan[r].op, plan[r].val, plan[r].typed, plan[r].want);
      end
    end

    while (phase < N_EXTREMES || live_reqs - ext_reqs < RANDOM_ITEMS) begin
      if (phase < N_EXTREMES) begin
        vals = '{ext_size[phase], ext_count[phase], {6'd0, ext_dir[phase]}};
      end else begin
        vals = '{pick_dim(), pick_dim(), 7'($urandom_range(0, 1))};
      end
      first = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) begin
        wait_drained();
        cfg_write(CFG_IDX_W'((first + k) % 3), vals[(first + k) % 3]);
      end
      if ($urandom_range(0, 3) == 0) begin
        wait_drained();
        cfg_write(CFG_NO_REG, 7'($urandom));
      end
      repeat ((phase < N_EXTREMES || batch_total() > 512) ? 1 : $urandom_range(1, 4))
        run_batch();
      phase++;
      if (phase == N_EXTREMES) ext_reqs = live_reqs;
      if (phase > N_EXTREMES && live_reqs - ext_reqs > RANDOM_ITEMS * 9 / 10) calm = 1'b1;
    end

    calm = 1'b1;
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // receiver pacing; one long hold early in the run backs up the input
  initial begin : rx_pacing
    int unsigned rx_rate;
    rx_rate = 1;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 255) == 0) rx_rate = $urandom_range(0, 3);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(1, 12) <= rx_rate) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    shuffle_rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected result byte=%02h last=%b error=%b",
                 $time, out_byte, out_last, out_error);
        mismatches++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_byte !== want.data) begin
          $display("%0t: out_byte expected %02h got %02h", $time, want.data, out_byte);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $display("%0t: out_last expected %b got %b", $time, want.last, out_last);
          mismatches++;
        end
        if (out_error !== want.err) begin
          $display("%0t: out_error expected %b got %b", $time, want.err, out_error);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

// ----- sim.f -----
rtl/rbt_pkg.sv
rtl/rbt_ram.sv
rtl/rbt_datapath.sv
rtl/rbt_ctrl.sv
rtl/record_byte_transposer.sv
sim/record_byte_transposer_tb.sv
